### rtl/ccx_pkg.sv
`timescale 1ns / 1ps
// ccx_pkg: constants, types and round functions shared by the ChaCha20 stream XOR block.
// No dependencies.

package ccx_pkg;

    localparam int DOUBLE_ROUNDS   = 10;
    localparam int BYTES_PER_ITEM  = 8;
    localparam int ITEMS_PER_BLOCK = 64 / BYTES_PER_ITEM;
    localparam int ITEM_LANES      = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;
    localparam int POS_W           = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;
    localparam int ROUND_STEPS     = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W          = $clog2(ROUND_STEPS);
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                          32'h79622d32, 32'h6b206574};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD0,
        REG_KEY_WORD1,
        REG_KEY_WORD2,
        REG_KEY_WORD3,
        REG_NONCE_LOW,
        REG_NONCE_HIGH,
        REG_INITIAL_COUNTER
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

    typedef enum logic {
        BACK_RUN,
        BACK_GEN
    } back_state_t;

    typedef logic [15:0][31:0] block_t;
    typedef logic [3:0][31:0]  quad_t;

    // One queued word plus what the back end needs to process it.
    typedef struct packed {
        logic [63:0]      data_word;
        logic [3:0]       valid_bytes;
        logic             last_word;
        logic             need_block;
        logic [31:0]      counter;
        logic [POS_W-1:0] pos;
    } ccx_job_t;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_low;
        logic [31:0]      nonce_high;
    } ccx_key_t;

    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } core_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // Half a quarter round: first half uses rotates 16/12, second half 8/7.
    // Quad order: [0]=a, [1]=b, [2]=c, [3]=d.
    function automatic quad_t half_qr(input quad_t q, input logic second);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        quad_t       r;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b;
        d = second ? rotl32(d ^ a, 8) : rotl32(d ^ a, 16);
        c = c + d;
        b = second ? rotl32(b ^ c, 7) : rotl32(b ^ c, 12);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

### rtl/ccx_if.sv
`timescale 1ns / 1ps
// ccx_if: valid/ready channel interfaces for data words, results and register writes.
// Depends on ccx_pkg.

interface ccx_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;

    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface ccx_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic [3:0]  out_valid_bytes;
    logic        out_last;

    modport source (output valid, out_word, out_valid_bytes, out_last, input ready);
    modport sink   (input valid, out_word, out_valid_bytes, out_last, output ready);
endinterface

interface ccx_cfg_if import ccx_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ccx_front.sv
`timescale 1ns / 1ps
// ccx_front: accepts data words, tracks message/block position and block counter,
// and tags each word for the back end. Depends on ccx_pkg.

module ccx_front
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [63:0] item_data_word,
    input  logic [3:0]  item_valid_bytes,
    input  logic        item_last_word,
    input  logic [31:0] initial_counter,
    input  logic        queue_full,
    output logic        push,
    output ccx_job_t    job
);

    logic [31:0]      block_counter_reg, block_counter_next;
    logic [POS_W-1:0] word_position_reg, word_position_next;
    logic             message_open_reg, message_open_next;

    logic [31:0]      ctr;
    logic [POS_W-1:0] pos;
    logic             need;

    assign item_ready = !queue_full;
    assign push       = item_valid && item_ready;

    always_comb
    begin
        ctr  = message_open_reg ? block_counter_reg : initial_counter;
        pos  = message_open_reg ? word_position_reg : '0;
        need = (pos == '0);

        job.data_word   = item_data_word;
        job.valid_bytes = item_valid_bytes;
        job.last_word   = item_last_word;
        job.need_block  = need;
        job.counter     = ctr;
        job.pos         = pos;

        block_counter_next = block_counter_reg;
        word_position_next = word_position_reg;
        message_open_next  = message_open_reg;
        if (push)
        begin
            block_counter_next = need ? ctr + 32'd1 : ctr;
            if (pos == POS_W'(ITEMS_PER_BLOCK - 1))
                word_position_next = '0;
            else
                word_position_next = pos + POS_W'(1);
            message_open_next = !item_last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_counter_reg <= '0;
            word_position_reg <= '0;
            message_open_reg  <= 1'b0;
        end
        else
        begin
            block_counter_reg <= block_counter_next;
            word_position_reg <= word_position_next;
            message_open_reg  <= message_open_next;
        end
    end

endmodule

### rtl/ccx_queue.sv
`timescale 1ns / 1ps
// ccx_queue: short register FIFO of tagged words between front and back end.
// Depends on ccx_pkg.

module ccx_queue
    import ccx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ccx_job_t job,
    input  logic     pop,
    output ccx_job_t head,
    output logic     head_valid,
    output logic     full
);

    ccx_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job;
    end

endmodule

### rtl/ccx_core.sv
`timescale 1ns / 1ps
// ccx_core: iterative ChaCha20 block function, four half quarter rounds per cycle,
// then feed-forward. Holds the current keystream block. Depends on ccx_pkg.

module ccx_core
    import ccx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_req_t  req,
    input  ccx_key_t   keys,
    output core_stat_t stat,
    output block_t     block
);

    core_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    block_t            x_reg, x_next;
    block_t            init_reg, init_next;
    block_t            ks_reg, ks_next;

    block_t            init_state;
    block_t            x_step;

    assign block     = ks_reg;
    assign stat.busy = (state_reg != CORE_IDLE);
    assign stat.done = done_reg;

    always_comb
    begin
        init_state[0]  = SIGMA[0];
        init_state[1]  = SIGMA[1];
        init_state[2]  = SIGMA[2];
        init_state[3]  = SIGMA[3];
        init_state[4]  = keys.key[0][31:0];
        init_state[5]  = keys.key[0][63:32];
        init_state[6]  = keys.key[1][31:0];
        init_state[7]  = keys.key[1][63:32];
        init_state[8]  = keys.key[2][31:0];
        init_state[9]  = keys.key[2][63:32];
        init_state[10] = keys.key[3][31:0];
        init_state[11] = keys.key[3][63:32];
        init_state[12] = req.counter;
        init_state[13] = keys.nonce_low[31:0];
        init_state[14] = keys.nonce_low[63:32];
        init_state[15] = keys.nonce_high;
    end

    // step[0] picks the half, step[1] picks column or diagonal round.
    always_comb
    begin
        int    r;
        int    bi;
        int    ci;
        int    di;
        quad_t qi;
        quad_t qo;
        x_step = x_reg;
        r      = int'(step_reg[1]);
        for (int q = 0; q < 4; q++)
        begin
            bi    = 4 + ((q + r) & 3);
            ci    = 8 + ((q + 2 * r) & 3);
            di    = 12 + ((q + 3 * r) & 3);
            qi[0] = x_reg[q];
            qi[1] = x_reg[bi];
            qi[2] = x_reg[ci];
            qi[3] = x_reg[di];
            qo    = half_qr(qi, step_reg[0]);
            x_step[q]  = qo[0];
            x_step[bi] = qo[1];
            x_step[ci] = qo[2];
            x_step[di] = qo[3];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        init_next  = init_reg;
        ks_next    = ks_reg;
        case (state_reg)
            CORE_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = init_state;
                    init_next  = init_state;
                    step_next  = '0;
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                x_next    = x_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROUND_STEPS - 1))
                    state_next = CORE_ADD;
            end
            CORE_ADD:
            begin
                for (int i = 0; i < 16; i++)
                    ks_next[i] = x_reg[i] + init_reg[i];
                done_next  = 1'b1;
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        init_reg <= init_next;
        ks_reg   <= ks_next;
    end

endmodule

### rtl/ccx_back.sv
`timescale 1ns / 1ps
// ccx_back: takes tagged words from the queue, requests blocks from the core,
// XORs keystream and masks invalid bytes into the output register. Depends on ccx_pkg.

module ccx_back
    import ccx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ccx_job_t    head,
    input  logic        head_valid,
    output logic        pop,
    output core_req_t   req,
    input  core_stat_t  stat,
    input  block_t      block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word,
    output logic [3:0]  out_valid_bytes,
    output logic        out_last
);

    back_state_t state_reg, state_next;
    logic        blk_ready_reg, blk_ready_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_word_reg;
    logic [3:0]  out_vb_reg;
    logic        out_last_reg;

    logic [63:0][7:0] ks_bytes;
    logic [63:0]      ks;
    logic [63:0]      mask;
    logic [3:0]       eff;
    logic             slot_free;

    assign ks_bytes        = block;
    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;
    assign out_valid_bytes = out_vb_reg;
    assign out_last        = out_last_reg;
    assign slot_free       = !out_valid_reg || out_ready;

    always_comb
    begin
        logic [5:0] bidx;
        ks = '0;
        for (int lane = 0; lane < ITEM_LANES; lane++)
        begin
            bidx = 6'(int'(head.pos) * BYTES_PER_ITEM + lane);
            ks[lane*8 +: 8] = ks_bytes[bidx];
        end
        eff = (head.valid_bytes > 4'd8) ? 4'd8 : head.valid_bytes;
        if (eff > 4'(ITEM_LANES))
            eff = 4'(ITEM_LANES);
        for (int lane = 0; lane < 8; lane++)
            mask[lane*8 +: 8] = (4'(lane) < eff) ? 8'hff : 8'h00;
    end

    always_comb
    begin
        state_next     = state_reg;
        blk_ready_next = blk_ready_reg;
        req.start      = 1'b0;
        req.counter    = head.counter;
        case (state_reg)
            BACK_RUN:
            begin
                if (head_valid && head.need_block && !blk_ready_reg && !stat.busy)
                begin
                    req.start  = 1'b1;
                    state_next = BACK_GEN;
                end
            end
            BACK_GEN:
            begin
                if (stat.done)
                begin
                    blk_ready_next = 1'b1;
                    state_next     = BACK_RUN;
                end
            end
            default:
            begin
                state_next = BACK_RUN;
            end
        endcase

        pop = head_valid && (!head.need_block || blk_ready_reg) && slot_free;
        if (pop && head.need_block)
            blk_ready_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_RUN;
            blk_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_ready_reg <= blk_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= (head.data_word ^ ks) & mask;
            out_vb_reg   <= head.valid_bytes;
            out_last_reg <= head.last_word;
        end
    end

endmodule

### rtl/chacha20_stream_xor.sv
`timescale 1ns / 1ps
// chacha20_stream_xor: top level of the ChaCha20 (96-bit nonce) stream XOR block.
// Depends on ccx_pkg, ccx_if, ccx_front, ccx_queue, ccx_core, ccx_back.
//
// Usage:
//   item   - input words: 8 data bytes (byte 0 in bits 7:0), valid byte count, last flag.
//   result - one output word per input word: data XOR keystream, bytes past the
//            valid count zeroed, valid count and last flag copied through.
//   cfg    - register writes (key words 0..3, nonce low/high, initial counter);
//            always ready, write only while no word is in flight. Unknown index ignored.
// A message starts with the first word after reset or after a word marked last;
// its first block uses the initial counter, and the counter steps per 64-byte block.
// Timing: an accepted word is written into the queue and from the queue head XORed
// into the output register; the first word of each block also waits for its keystream
// block, set by the iterative round unit doing one half quarter round per
// column/diagonal lane each cycle, plus the feed-forward and block hand-off.
// Throughput: one word per cycle inside a block while the receiver takes results; the
// next block's keystream is only started when its first word reaches the queue head.
// Reset (rst_n low, async) clears control, counter, config and message-state registers.
// If the receiver stalls, the output register holds its word; the two-entry queue
// keeps accepting until full, then item.ready drops.

module chacha20_stream_xor
    import ccx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ccx_in_if.sink       item,
    ccx_out_if.source    result,
    ccx_cfg_if.sink      cfg
);

    // configuration registers
    logic [3:0][63:0] key_reg;
    logic [63:0]      nonce_low_reg;
    logic [31:0]      nonce_high_reg;
    logic [31:0]      init_ctr_reg;

    ccx_key_t   keys;
    ccx_job_t   push_job;
    ccx_job_t   head;
    logic       push;
    logic       pop;
    logic       head_valid;
    logic       queue_full;
    core_req_t  core_req;
    core_stat_t core_stat;
    block_t     ks_block;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_KEY_WORD0:       key_reg[0]     <= cfg.data;
                REG_KEY_WORD1:       key_reg[1]     <= cfg.data;
                REG_KEY_WORD2:       key_reg[2]     <= cfg.data;
                REG_KEY_WORD3:       key_reg[3]     <= cfg.data;
                REG_NONCE_LOW:       nonce_low_reg  <= cfg.data;
                REG_NONCE_HIGH:      nonce_high_reg <= cfg.data[31:0];
                REG_INITIAL_COUNTER: init_ctr_reg   <= cfg.data[31:0];
                default:             ;
            endcase
        end
    end

    assign keys.key        = key_reg;
    assign keys.nonce_low  = nonce_low_reg;
    assign keys.nonce_high = nonce_high_reg;

    // front: accept, position and counter bookkeeping
    ccx_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item.valid),
        .item_ready       (item.ready),
        .item_data_word   (item.data_word),
        .item_valid_bytes (item.valid_bytes),
        .item_last_word   (item.last_word),
        .initial_counter  (init_ctr_reg),
        .queue_full       (queue_full),
        .push             (push),
        .job              (push_job)
    );

    ccx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .job        (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    ccx_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .keys  (keys),
        .stat  (core_stat),
        .block (ks_block)
    );

    // back: keystream XOR and output register
    ccx_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .req             (core_req),
        .stat            (core_stat),
        .block           (ks_block),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_word        (result.out_word),
        .out_valid_bytes (result.out_valid_bytes),
        .out_last        (result.out_last)
    );

endmodule

### rtl/ccx_checker.sv
`timescale 1ns / 1ps
// ccx_checker: port-level assertions for chacha20_stream_xor, bound to the top level.
// Depends on ccx_pkg and chacha20_stream_xor.

module ccx_checker
    import ccx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_word,
    input logic [3:0]  out_valid_bytes,
    input logic        cfg_ready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_valid_bytes == 4'd0 |-> out_word == 64'd0)
        else $error("word with zero valid bytes is not zero");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_valid_bytes < 4'd8 |-> (out_word >> {out_valid_bytes, 3'b000}) == 64'd0)
        else $error("bytes past valid count are not zero");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind chacha20_stream_xor ccx_checker u_ccx_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_word        (result.out_word),
    .out_valid_bytes (result.out_valid_bytes),
    .cfg_ready       (cfg.ready)
);
